/* rtl/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and lookup functions for the UTF-8 to UTF-16
// decoder: result kinds, the result bundle and the per-length tables.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_OK       = 2'd1,
    KIND_INVALID  = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  // One result item
  typedef struct packed {
    logic [15:0] word;
    kind_t       kind;
  } res_t;

  // Up to three results caused by one byte
  typedef struct packed {
    logic [1:0]     cnt;
    res_t [2:0]     res;
  } bundle_t;

  localparam logic [31:0] CpMax      = 32'h0010_FFFF;
  localparam logic [31:0] SurrLo     = 32'h0000_D800;
  localparam logic [31:0] SurrHi     = 32'h0000_DFFF;
  localparam logic [15:0] HiSurrBase = 16'hD7C0;
  localparam logic [15:0] LoSurrBase = 16'hDC00;

  // Sequence length from the lead byte, 0 for a byte that cannot lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    priority if (b < 8'h80) len = 3'd1;
    else if (b < 8'hC0) len = 3'd0;
    else if (b < 8'hE0) len = 3'd2;
    else if (b < 8'hF0) len = 3'd3;
    else if (b < 8'hF8) len = 3'd4;
    else if (b < 8'hFC) len = 3'd5;
    else if (b < 8'hFE) len = 3'd6;
    else len = 3'd0;
    return len;
  endfunction

  // Lead and marker bits folded into the accumulator, per length
  function automatic logic [31:0] magic_sub(input logic [2:0] len);
    logic [31:0] m;
    unique case (len)
      3'd2:    m = 32'h0000_3080;
      3'd3:    m = 32'h000E_2080;
      3'd4:    m = 32'h03C8_2080;
      3'd5:    m = 32'hFA08_2080;
      3'd6:    m = 32'h8208_2080;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

  // Smallest code point that needs this length (overlong check); all ones for five and six bytes
  function automatic logic [31:0] shortest_min(input logic [2:0] len);
    logic [31:0] m;
    unique case (len)
      3'd2:       m = 32'h0000_0080;
      3'd3:       m = 32'h0000_0800;
      3'd4:       m = 32'h0001_0000;
      3'd5, 3'd6: m = 32'hFFFF_FFFF;
      default:    m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

/* rtl/u8u16_dec.sv */
// ----------------------------------------------------------------------------
// u8u16_dec
// Decode stage: holds the per-string state and turns one registered byte
// into a bundle of up to three results, combinationally.
// ----------------------------------------------------------------------------
module u8u16_dec
  import u8u16_pkg::*;
#(
  parameter int unsigned UNIT_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  byte_in,
  input  logic        eos_in,
  input  logic [15:0] capacity,
  output bundle_t     bundle
);

  localparam int unsigned UW    = UNIT_COUNT_BITS;
  localparam int unsigned CMP_W = ((UW > 16) ? UW : 16) + 1;

  // Per-string state
  logic [31:0]   acc_r,    acc_nxt;
  logic [2:0]    seq_len_r, seq_len_nxt;
  logic [2:0]    seen_r,   seen_nxt;
  logic          mal_r,    mal_nxt;
  logic          supp_r,   supp_nxt;
  logic          failed_r, failed_nxt;
  logic [UW-1:0] units_r,  units_nxt;

  // Effective capacity, limited by the counter width
  logic [CMP_W-1:0] cap_lim, cap_ext, cap_eff, units_ext, units_p2;

  assign cap_lim   = CMP_W'((64'd1 << UW) - 64'd1);
  assign cap_ext   = CMP_W'(capacity);
  assign cap_eff   = (cap_ext < cap_lim) ? cap_ext : cap_lim;
  assign units_ext = CMP_W'(units_r);
  assign units_p2  = units_ext + CMP_W'(2);

  // Trail byte folding and code point
  logic [2:0]  len_lead;
  logic [31:0] acc_fold, cp;
  logic [2:0]  seen_inc;
  logic        mal_fold, cp_bad;

  assign len_lead = lead_len(byte_in);
  assign acc_fold = {acc_r[25:0], 6'b0} + {24'b0, byte_in};
  assign seen_inc = seen_r + 3'd1;
  assign mal_fold = mal_r | (byte_in[7:6] != 2'b10);
  assign cp       = acc_fold - magic_sub(seq_len_r);
  assign cp_bad   = mal_fold || (cp > CpMax) || (cp < shortest_min(seq_len_r)) ||
                    ((cp >= SurrLo) && (cp <= SurrHi));

  // Next state and result bundle
  always_comb begin
    logic [1:0] n;
    n           = 2'd0;
    bundle      = '0;
    acc_nxt     = acc_r;
    seq_len_nxt = seq_len_r;
    seen_nxt    = seen_r;
    mal_nxt     = mal_r;
    supp_nxt    = supp_r;
    failed_nxt  = failed_r;
    units_nxt   = units_r;

    if (!failed_r) begin
      if (seq_len_r == 3'd0) begin
        if (units_ext >= cap_eff) begin
          bundle.res[n] = '{word: 16'h0, kind: KIND_OVERFLOW};
          n             = n + 2'd1;
          failed_nxt    = 1'b1;
        end else if (len_lead == 3'd0) begin
          bundle.res[n] = '{word: 16'h0, kind: KIND_INVALID};
          n             = n + 2'd1;
          failed_nxt    = 1'b1;
        end else if (len_lead == 3'd1) begin
          bundle.res[n] = '{word: {8'h0, byte_in}, kind: KIND_DATA};
          n             = n + 2'd1;
          units_nxt     = units_r + UW'(1);
        end else begin
          acc_nxt     = {24'b0, byte_in};
          seq_len_nxt = len_lead;
          seen_nxt    = 3'd1;
          mal_nxt     = 1'b0;
          supp_nxt    = (byte_in >= 8'hF0);
        end
      end else begin
        acc_nxt  = acc_fold;
        seen_nxt = seen_inc;
        mal_nxt  = mal_fold;
        // Sequence complete
        if (seen_inc >= seq_len_r) begin
          seq_len_nxt = 3'd0;
          if (cp_bad) begin
            bundle.res[n] = '{word: 16'h0, kind: KIND_INVALID};
            n             = n + 2'd1;
            failed_nxt    = 1'b1;
          end else if (supp_r) begin
            if (units_p2 > cap_eff) begin
              bundle.res[n] = '{word: 16'h0, kind: KIND_OVERFLOW};
              n             = n + 2'd1;
              failed_nxt    = 1'b1;
            end else begin
              // high half takes cp[20:10], up to 0x43F
              bundle.res[n] = '{word: HiSurrBase + {5'b0, cp[20:10]},
                                kind: KIND_DATA};
              n             = n + 2'd1;
              bundle.res[n] = '{word: LoSurrBase + {6'b0, cp[9:0]},
                                kind: KIND_DATA};
              n             = n + 2'd1;
              units_nxt     = units_r + UW'(2);
            end
          end else begin
            bundle.res[n] = '{word: cp[15:0], kind: KIND_DATA};
            n             = n + 2'd1;
            units_nxt     = units_r + UW'(1);
          end
        end
      end
    end

    // End of string: status, then back to a clean string
    if (eos_in) begin
      if (!failed_nxt) begin
        if (seq_len_nxt != 3'd0) begin
          bundle.res[n] = '{word: 16'h0, kind: KIND_INVALID};
        end else begin
          bundle.res[n] = '{word: 16'h0, kind: KIND_OK};
        end
        n = n + 2'd1;
      end
      acc_nxt     = '0;
      seq_len_nxt = '0;
      seen_nxt    = '0;
      mal_nxt     = 1'b0;
      supp_nxt    = 1'b0;
      failed_nxt  = 1'b0;
      units_nxt   = '0;
    end

    bundle.cnt = n;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      seq_len_r <= '0;
      seen_r    <= '0;
      mal_r     <= 1'b0;
      supp_r    <= 1'b0;
      failed_r  <= 1'b0;
      units_r   <= '0;
    end else if (fire) begin
      acc_r     <= acc_nxt;
      seq_len_r <= seq_len_nxt;
      seen_r    <= seen_nxt;
      mal_r     <= mal_nxt;
      supp_r    <= supp_nxt;
      failed_r  <= failed_nxt;
      units_r   <= units_nxt;
    end
  end

  // A failed string never has a sequence open
  a_failed_closed: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> (seq_len_r == 3'd0))
    else $error("sequence open after failure");

  // While a sequence is open fewer bytes than its length have been seen
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_len_r != 3'd0) |-> ((seen_r < seq_len_r) && (seq_len_r >= 3'd2)))
    else $error("byte count outside open sequence");

endmodule

/* rtl/u8u16_outbuf.sv */
// ----------------------------------------------------------------------------
// u8u16_outbuf
// Result register: holds one bundle and hands its results out one per
// transaction, flagging the last one of the bundle.
// ----------------------------------------------------------------------------
module u8u16_outbuf
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  bundle_t     bundle,
  output logic        free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_word,
  output logic [1:0]  out_kind,
  output logic        out_last_of_run
);

  logic [1:0]     cnt_r;
  logic [1:0]     idx_r;
  res_t [2:0]     res_r;
  logic           take, last;

  assign out_valid       = (cnt_r != 2'd0);
  assign take            = out_valid && !out_stall;
  assign last            = (idx_r == (cnt_r - 2'd1));
  assign free            = !out_valid || (take && last);
  assign out_word        = res_r[idx_r].word;
  assign out_kind        = res_r[idx_r].kind;
  assign out_last_of_run = last;

  // Control: count and read index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      cnt_r <= bundle.cnt;
      idx_r <= 2'd0;
    end else if (take) begin
      if (last) begin
        cnt_r <= 2'd0;
        idx_r <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= bundle.res;
    end
  end

  // Read index stays inside the held bundle
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (idx_r < cnt_r))
    else $error("read index past bundle");

  // A bundle is only replaced once its last result has gone
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid || (!out_stall && last)))
    else $error("bundle overwritten with results pending");

endmodule

/* rtl/utf8_to_utf16_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Streaming UTF-8 to UTF-16 transcoder: one byte in, up to three results
// out (data units, then a status at the end of the string).
//
//   Channel  Handshake        Payload
//   in       in_valid/stall   in_byte, in_end_of_string
//   out      out_valid/stall  out_word, out_kind, out_last_of_run
//   cfg      cfg_valid/ready  cfg_out_capacity
//
// One byte per cycle is taken while each byte gives at most one result and
// out does not stall; a byte giving several results holds the input until
// the single result register has sent them, one result a cycle unless stalled.
// A byte's first result comes out of the result register, behind the input register.
// Reset is synchronous, active low; capacity returns to 65535.
// A stall on out backs up into in_stall once the input register is full.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder
  import u8u16_pkg::*;
#(
  parameter int unsigned UNIT_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_string,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_word,
  output logic [1:0]  out_kind,
  output logic        out_last_of_run,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_out_capacity
);

  logic        in_valid_r;
  logic [7:0]  byte_r;
  logic        eos_r;
  logic [15:0] capacity_r;
  logic        free, fire, accept;
  bundle_t     bundle;

  assign cfg_ready = 1'b1;
  assign fire      = in_valid_r && free;
  assign in_stall  = in_valid_r && !free;
  assign accept    = in_valid && !in_stall;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_out_capacity;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (accept) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte;
      eos_r  <= in_end_of_string;
    end
  end

  u8u16_dec #(
    .UNIT_COUNT_BITS (UNIT_COUNT_BITS)
  ) u_dec (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .byte_in  (byte_r),
    .eos_in   (eos_r),
    .capacity (capacity_r),
    .bundle   (bundle)
  );

  u8u16_outbuf u_outbuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (fire),
    .bundle          (bundle),
    .free            (free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word        (out_word),
    .out_kind        (out_kind),
    .out_last_of_run (out_last_of_run)
  );

  // A held byte is decoded once the result register frees up
  a_byte_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_valid) |=> (!in_valid_r || $past(accept)))
    else $error("byte held with result register empty");

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 to UTF-16 decoder. UTF-8 strings are
// queued and fed one byte per transaction in bursts. A behavioural transcoder
// in the bench predicts each byte's UTF-16 units and status. Every result is
// compared field by field against the oldest prediction while the result side
// stalls in shifting patterns. The capacity register is reprogrammed between
// phases, covering zero, one or two free slots and the full 16-bit range.
// ----------------------------------------------------------------------------
module tb
  import u8u16_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One predicted UTF-16 result
  typedef struct {
    logic [15:0] code;
    kind_t       kind;
    logic        last;
  } utf16_res_t;

  // Marker bits left in the accumulator, and the shortest code point, per length
  localparam logic [31:0] LEAD_MARKS [8] = '{32'h0, 32'h0, 32'h0000_3080, 32'h000E_2080,
                                            32'h03C8_2080, 32'hFA08_2080, 32'h8208_2080,
                                            32'h0};
  localparam logic [31:0] SHORTEST [8] = '{32'h0, 32'h0, 32'h80, 32'h800, 32'h1_0000,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0};

  // Directed strings at full capacity; bit 8 marks the end of the string
  localparam logic [8:0] PLAIN_CASES [28] = '{
    // U+0000, U+0080, U+FFFF, U+10FFFF as a pair
    9'h000, 9'h0C2, 9'h080, 9'h0EF, 9'h0BF, 9'h0BF, 9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,
    // overlong pair, then a byte swallowed by the sticky failure
    9'h0C0, 9'h080, 9'h141,
    // surrogate, above U+10FFFF
    9'h0ED, 9'h0A0, 9'h180,
    9'h0F4, 9'h090, 9'h080, 9'h180,
    // bytes that cannot lead
    9'h180, 9'h1FF,
    // six-byte lead cut short by the end of the string
    9'h0FC, 9'h180,
    // malformed trail, truncated three-byte sequence
    9'h0C2, 9'h141,
    9'h07F, 9'h1E0
  };

  // Directed strings with a capacity of two units
  localparam logic [8:0] TIGHT_CASES [13] = '{
    // pair with one slot left overflows, rest ignored
    9'h041, 9'h0F0, 9'h090, 9'h080, 9'h080, 9'h141,
    // third unit overflows at its lead byte
    9'h041, 9'h042, 9'h143,
    // pair fills both slots exactly
    9'h0F0, 9'h090, 9'h080, 9'h180
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_end_of_string = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_word;
  logic [1:0]  out_kind;
  logic        out_last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_out_capacity = 16'h0000;

  // Bytes waiting to be sent, and UTF-16 results still to arrive
  logic [8:0]  utf8_bytes [$];
  utf16_res_t  utf16_due [$];
  int          mismatches = 0;

  // Transcoder state mirrored by the bench
  logic [15:0] capacity = 16'hFFFF;
  logic [31:0] cp_acc = '0;
  logic [2:0]  seq_len = '0;
  logic [2:0]  seq_pos = '0;
  logic        trail_bad = 1'b0;
  logic        needs_pair = 1'b0;
  logic        str_failed = 1'b0;
  int unsigned units_out = 0;

  // Sender bursts and receiver stall pattern
  int          burst_left = 0;
  int          gap_left = 0;
  int unsigned stall_tick = 0;
  int          stall_mode = 0;

  utf8_to_utf16_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_word         (out_word),
    .out_kind         (out_kind),
    .out_last_of_run  (out_last_of_run),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_out_capacity (cfg_out_capacity)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predict the results of one accepted byte
  task automatic transcode_byte(input logic [7:0] b, input logic eos);
    utf16_res_t  r [$];
    logic [2:0]  len;
    logic [31:0] cp;
    if (!str_failed) begin
      if (seq_len == 3'd0) begin
        if (b < 8'h80) len = 3'd1;
        else if (b < 8'hC0) len = 3'd0;
        else if (b < 8'hE0) len = 3'd2;
        else if (b < 8'hF0) len = 3'd3;
        else if (b < 8'hF8) len = 3'd4;
        else if (b < 8'hFC) len = 3'd5;
        else if (b < 8'hFE) len = 3'd6;
        else len = 3'd0;
        if (units_out >= capacity) begin
          r.push_back('{code: 16'h0, kind: KIND_OVERFLOW, last: 1'b0});
          str_failed = 1'b1;
        end else if (len == 3'd0) begin
          r.push_back('{code: 16'h0, kind: KIND_INVALID, last: 1'b0});
          str_failed = 1'b1;
        end else if (len == 3'd1) begin
          r.push_back('{code: {8'h00, b}, kind: KIND_DATA, last: 1'b0});
          units_out++;
        end else begin
          cp_acc = {24'h0, b};
          seq_len = len;
          seq_pos = 3'd1;
          trail_bad = 1'b0;
          needs_pair = (b >= 8'hF0);
        end
      end else begin
        // trail byte: fold in six bits, close the sequence when complete
        if (b[7:6] != 2'b10) trail_bad = 1'b1;
        cp_acc = (cp_acc << 6) + {24'h0, b};
        seq_pos = seq_pos + 3'd1;
        if (seq_pos >= seq_len) begin
          cp = cp_acc - LEAD_MARKS[seq_len];
          if (trail_bad || cp > 32'h0010_FFFF || cp < SHORTEST[seq_len] ||
              (cp >= 32'hD800 && cp <= 32'hDFFF)) begin
            r.push_back('{code: 16'h0, kind: KIND_INVALID, last: 1'b0});
            str_failed = 1'b1;
          end else if (needs_pair) begin
            if (units_out + 2 > capacity) begin
              r.push_back('{code: 16'h0, kind: KIND_OVERFLOW, last: 1'b0});
              str_failed = 1'b1;
            end else begin
              r.push_back('{code: 16'hD7C0 + cp[25:10], kind: KIND_DATA, last: 1'b0});
              r.push_back('{code: 16'hDC00 + {6'h0, cp[9:0]}, kind: KIND_DATA, last: 1'b0});
              units_out += 2;
            end
          end else begin
            r.push_back('{code: cp[15:0], kind: KIND_DATA, last: 1'b0});
            units_out++;
          end
          seq_len = 3'd0;
        end
      end
    end
    // end of string: status unless already failed, then a clean slate
    if (eos) begin
      if (!str_failed) begin
        if (seq_len != 3'd0) r.push_back('{code: 16'h0, kind: KIND_INVALID, last: 1'b0});
        else r.push_back('{code: 16'h0, kind: KIND_OK, last: 1'b0});
      end
      cp_acc = '0;
      seq_len = '0;
      seq_pos = '0;
      trail_bad = 1'b0;
      needs_pair = 1'b0;
      str_failed = 1'b0;
      units_out = 0;
    end
    if (r.size() != 0) r[r.size() - 1].last = 1'b1;
    foreach (r[i]) utf16_due.push_back(r[i]);
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic eos);
    utf8_bytes.push_back({eos, b});
  endtask

  // Encode a code point into n bytes, masking off bits that do not fit
  task automatic append_seq(ref logic [7:0] s [$], input logic [31:0] cp, input int n);
    logic [7:0] lead;
    if (n == 1) begin
      s.push_back(cp[7:0]);
    end else begin
      lead = (8'hFF << (8 - n)) | (8'((cp >> (6 * (n - 1)))) & (8'hFF >> (n + 1)));
      s.push_back(lead);
      for (int k = n - 2; k >= 0; k--) s.push_back(8'h80 | (8'(cp >> (6 * k)) & 8'h3F));
    end
  endtask

  // Random strings, mostly well-formed characters with some broken ones
  task automatic queue_random_strings(input int n_bytes);
    logic [7:0]  s [$];
    logic [7:0]  b;
    logic [31:0] cp;
    int          added = 0;
    int          sel;
    int          n;
    while (added < n_bytes) begin
      s.delete();
      repeat ($urandom_range(1, 6)) begin
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
          append_seq(s, $urandom_range(0, 'h7F), 1);
        end else if (sel < 43) begin
          append_seq(s, $urandom_range('h80, 'h7FF), 2);
        end else if (sel < 63) begin
          cp = $urandom_range(0, 1) ? $urandom_range('h800, 'hD7FF)
                                    : $urandom_range('hE000, 'hFFFF);
          append_seq(s, cp, 3);
        end else if (sel < 80) begin
          append_seq(s, $urandom_range('h1_0000, 'h10_FFFF), 4);
        end else if (sel < 84) begin
          s.push_back(8'($urandom));
        end else if (sel < 87) begin
          // overlong form
          n = $urandom_range(2, 4);
          append_seq(s, $urandom_range(0, SHORTEST[n] - 1), n);
        end else if (sel < 89) begin
          append_seq(s, $urandom_range('hD800, 'hDFFF), 3);
        end else if (sel < 91) begin
          append_seq(s, $urandom_range('h11_0000, 'h1F_FFFF), 4);
        end else if (sel < 93) begin
          // five or six byte form
          append_seq(s, $urandom, $urandom_range(5, 6));
        end else if (sel < 97) begin
          // one trail byte replaced by a non-trail byte
          n = $urandom_range(2, 4);
          append_seq(s, $urandom_range(SHORTEST[n], (32'h1 << (5 * n + 1)) - 1), n);
          b = 8'($urandom);
          if (b[7:6] == 2'b10) b[6] = 1'b1;
          s[s.size() - $urandom_range(1, n - 1)] = b;
        end else begin
          // sequence cut short
          n = $urandom_range(2, 4);
          append_seq(s, $urandom_range(SHORTEST[n], (32'h1 << (5 * n + 1)) - 1), n);
          repeat ($urandom_range(1, n - 1)) void'(s.pop_back());
        end
      end
      foreach (s[i]) queue_byte(s[i], i == s.size() - 1);
      added += s.size();
    end
  endtask

  // Wait until all bytes are sent and all results in, then let the pipe drain
  task automatic wait_idle();
    do @(negedge clk);
    while (utf8_bytes.size() != 0 || in_valid || utf16_due.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_out_capacity <= v;
    do @(negedge clk);
    while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    capacity = v;
    @(negedge clk);
  endtask

  // Byte driver: bursts of transactions with random gaps
  always @(posedge clk) begin : driver
    logic [8:0] nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) transcode_byte(in_byte, in_end_of_string);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (utf8_bytes.size() != 0) begin
          nxt = utf8_bytes.pop_front();
          in_valid <= 1'b1;
          in_byte <= nxt[7:0];
          in_end_of_string <= nxt[8];
          if (burst_left == 0) burst_left = $urandom_range(1, 20);
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and stall pattern
  always @(posedge clk) begin : monitor
    utf16_res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (utf16_due.size() == 0) begin
          $error("unexpected result: word %h, kind %0d, last_of_run %b",
                 out_word, out_kind, out_last_of_run);
          mismatches++;
        end else begin
          want = utf16_due.pop_front();
          if (out_word !== want.code) begin
            $error("word: expected %h, got %h", want.code, out_word);
            mismatches++;
          end
          if (out_kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_kind);
            mismatches++;
          end
          if (out_last_of_run !== want.last) begin
            $error("last_of_run: expected %b, got %b", want.last, out_last_of_run);
            mismatches++;
          end
        end
      end
      stall_tick++;
      if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ($urandom_range(0, 99) < 75);
        default: out_stall <= (stall_tick % 8 < 3);
      endcase
    end
  end

  // Phases of stimulus, capacity rewritten between them
  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (PLAIN_CASES[i]) queue_byte(PLAIN_CASES[i][7:0], PLAIN_CASES[i][8]);
    queue_random_strings(40);
    wait_idle();

    write_capacity(16'd2);
    foreach (TIGHT_CASES[i]) queue_byte(TIGHT_CASES[i][7:0], TIGHT_CASES[i][8]);
    queue_random_strings(20);
    wait_idle();

    // no room at all: every lead overflows, even one that cannot lead
    write_capacity(16'd0);
    queue_byte(8'h41, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_random_strings(15);
    wait_idle();

    write_capacity(16'hFFFF);
    queue_random_strings(140);
    wait_idle();

    write_capacity(16'($urandom_range(1, 10)));
    queue_random_strings(50);
    wait_idle();

    write_capacity(16'($urandom_range(0, 'hFFFF)));
    queue_random_strings(30);
    wait_idle();

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
